// ===== rtl/core/pit_pkg.sv =====
// Package: types, constants and state codes of the pending interest table.
package pit_pkg;
   localparam int ENTRIES   = 64;
   localparam int KEY_BITS  = 64;
   localparam int TIME_BITS = 32;
   localparam int IDX_BITS  = $clog2(ENTRIES);
   localparam int CNT_BITS  = $clog2(ENTRIES + 1);

   localparam logic [2:0] MODE_TICK     = 3'd0;
   localparam logic [2:0] MODE_INS_HELD = 3'd1;
   localparam logic [2:0] MODE_INSERT   = 3'd2;
   localparam logic [2:0] MODE_MATCH    = 3'd3;
   localparam logic [2:0] MODE_RELEASE  = 3'd4;
   localparam logic [2:0] MODE_REFRESH  = 3'd5;
   localparam logic [2:0] MODE_CLOSE    = 3'd6;
   localparam logic [2:0] MODE_QUERY    = 3'd7;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_ROOM = 2'd1;
   localparam logic [1:0] ST_NO_MATCH = 2'd2;
   localparam logic [1:0] ST_BAD_SLOT = 2'd3;

   typedef struct packed {
      logic [2:0]  mode;
      logic [63:0] name_key;
      logic [5:0]  entry_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  slot;
      logic        was_registered;
      logic        is_expired;
      logic [31:0] age;
   } rsp_type;

   // Time and key fields of one table entry, kept in memory.
   typedef struct packed {
      logic [KEY_BITS-1:0]  key;
      logic [TIME_BITS-1:0] created;
      logic [TIME_BITS-1:0] expiry;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_LAST, S_ACT, S_RD, S_OUT
   } state_type;

   function automatic logic expired(input logic [TIME_BITS-1:0] exp_t,
                                    input logic [TIME_BITS-1:0] now);
      logic [TIME_BITS-1:0] d;
      d = exp_t - now;
      return (d == '0) || d[TIME_BITS-1];
   endfunction
endpackage

// ===== rtl/core/pit_ram.sv =====
// Single-port entry memory with registered read.
module pit_ram
   import pit_pkg::*;
(
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_BITS-1:0] addr,
   input  entry_type           wr_data,
   output entry_type           rd_data
);
   entry_type mem [ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

// ===== rtl/core/pending_interest_table.sv =====
// Top level of the pending interest table: control, flag bits and scan.
//
//   channel | direction | handshake     | word
//   req_    | in        | valid / stall | req_type (mode, name_key, entry_index)
//   rsp_    | out       | valid / stall | rsp_type (status, slot, flags, age)
//   csr_    | in        | valid / ready | lifetime_ticks, 20 bits
//
// Tick passes S_ACT and S_OUT; addressed requests and free-slot inserts pass
// S_ACT, S_RD and S_OUT. Match and a full-table insert walk the entry memory
// one slot a cycle through its single port. Insert into a free slot needs no
// scan (priority encoder on the valid flops). Reset clears flag flops and time
// at once; no clearing pass. A result waits in the output register while
// rsp_stall is high; the next word is taken once the result has gone.
module pending_interest_table
   import pit_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [19:0] csr_data
);
   state_type state_ff, state_in;
   logic [ENTRIES-1:0] valid_ff, reg_ff, avail_ff, held_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [19:0] life_ff;
   req_type req_ff;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff;
   logic [IDX_BITS-1:0] ptr_ff, ptr_in;      // scan address
   logic [IDX_BITS-1:0] cur_ff;              // slot whose data arrives now
   logic [IDX_BITS-1:0] best_ff, best_in;
   logic [TIME_BITS-1:0] best_key_ff, best_key_in;
   logic found_ff, found_in;

   logic ram_we;
   logic [IDX_BITS-1:0] ram_addr;
   entry_type ram_wd, ram_rd;

   pit_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wd),
      .rd_data (ram_rd)
   );

   logic accept;
   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Lowest free slot.
   logic [IDX_BITS-1:0] free_idx;
   logic free_any;
   always_comb begin
      free_idx = '0;
      free_any = 1'b0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IDX_BITS'(i);
            free_any = 1'b1;
         end
      end
   end

   logic is_ins, is_match, addr_ok;
   assign is_ins   = (req_ff.mode == MODE_INS_HELD) || (req_ff.mode == MODE_INSERT);
   assign is_match = (req_ff.mode == MODE_MATCH);
   assign addr_ok  = (7'(req_ff.entry_index) < 7'(ENTRIES)) &&
                     valid_ff[req_ff.entry_index[IDX_BITS-1:0]];

   logic [TIME_BITS-1:0] cand_key, new_exp;
   logic cand_exp;
   assign cand_key = (ram_rd.expiry - now_ff) ^ {1'b1, {(TIME_BITS-1){1'b0}}};
   assign cand_exp = expired(ram_rd.expiry, now_ff);
   assign new_exp  = now_ff + TIME_BITS'(life_ff);

   logic [IDX_BITS-1:0] act_idx_ff, act_idx_in;
   logic wr_flags;

   always_comb begin
      state_in    = state_ff;
      ptr_in      = ptr_ff;
      best_in     = best_ff;
      best_key_in = best_key_ff;
      found_in    = found_ff;
      act_idx_in  = act_idx_ff;
      rsp_in      = rsp_ff;
      ram_we      = 1'b0;
      ram_addr    = ptr_ff;
      ram_wd      = '0;
      wr_flags    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            ptr_in   = '0;
            found_in = 1'b0;
            if (accept) begin
               state_in = S_ACT;
               if (req_data.mode == MODE_MATCH ||
                   ((req_data.mode == MODE_INS_HELD || req_data.mode == MODE_INSERT)
                    && !free_any)) begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN, S_LAST: begin
            // Data of cur_ff arrives; issue the next address.
            if (ptr_ff != '0 || state_ff == S_LAST) begin
               if (is_match) begin
                  if (!found_ff && valid_ff[cur_ff] && avail_ff[cur_ff] &&
                      ram_rd.key == req_ff.name_key[KEY_BITS-1:0] && !cand_exp) begin
                     found_in = 1'b1;
                     best_in  = cur_ff;
                  end
               end else if (!held_ff[cur_ff] && !reg_ff[cur_ff] &&
                            (!found_ff || cand_key < best_key_ff)) begin
                  found_in    = 1'b1;
                  best_in     = cur_ff;
                  best_key_in = cand_key;
               end
            end
            if (state_ff == S_LAST) begin
               state_in = S_ACT;
            end else if (ptr_ff == IDX_BITS'(ENTRIES - 1)) begin
               state_in = S_LAST;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         S_ACT: begin
            // Settle the slot and read its entry.
            act_idx_in = is_ins ? (free_any ? free_idx : best_ff)
                       : is_match ? best_ff : req_ff.entry_index[IDX_BITS-1:0];
            ram_addr = act_idx_in;
            state_in = S_RD;
            if (req_ff.mode == MODE_TICK) begin
               rsp_in   = '0;
               state_in = S_OUT;
            end else if ((is_ins && !free_any && !found_ff)) begin
               rsp_in = '0; rsp_in.status = ST_NO_ROOM; state_in = S_OUT;
            end else if (is_match && !found_ff) begin
               rsp_in = '0; rsp_in.status = ST_NO_MATCH; state_in = S_OUT;
            end else if (!is_ins && !is_match && !addr_ok) begin
               rsp_in = '0; rsp_in.status = ST_BAD_SLOT; state_in = S_OUT;
            end
         end
         S_RD: begin
            // Modify the flags, write the entry back on insert or refresh, and form the result.
            ram_addr = act_idx_ff;
            wr_flags = 1'b1;
            rsp_in   = '0;
            rsp_in.status = ST_OK;
            rsp_in.slot   = 6'(act_idx_ff);
            if (is_ins || req_ff.mode == MODE_REFRESH) begin
               ram_we         = 1'b1;
               ram_wd.key     = is_ins ? req_ff.name_key[KEY_BITS-1:0] : ram_rd.key;
               ram_wd.created = now_ff;
               ram_wd.expiry  = new_exp;
               rsp_in.was_registered = is_ins ? (req_ff.mode == MODE_INS_HELD)
                                              : reg_ff[act_idx_ff];
               rsp_in.is_expired = expired(new_exp, now_ff);
               rsp_in.age        = '0;
            end else begin
               rsp_in.was_registered = reg_ff[act_idx_ff];
               rsp_in.is_expired     = cand_exp;
               rsp_in.age            = 32'(now_ff - ram_rd.created);
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         reg_ff       <= '0;
         avail_ff     <= '0;
         held_ff      <= '0;
         now_ff       <= '0;
         life_ff      <= 20'd1000;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            life_ff <= csr_data;
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == S_OUT) begin
            rsp_valid_ff <= 1'b1;
            if (req_ff.mode == MODE_TICK) begin
               now_ff <= now_ff + 1'b1;
            end
         end
         if (wr_flags) begin
            unique case (req_ff.mode)
               MODE_INS_HELD, MODE_INSERT: begin
                  valid_ff[act_idx_ff] <= 1'b1;
                  avail_ff[act_idx_ff] <= 1'b1;
                  reg_ff[act_idx_ff]   <= (req_ff.mode == MODE_INS_HELD);
                  held_ff[act_idx_ff]  <= (req_ff.mode == MODE_INS_HELD);
               end
               MODE_MATCH: begin
                  avail_ff[act_idx_ff] <= 1'b0;
                  held_ff[act_idx_ff]  <= 1'b1;
               end
               MODE_RELEASE: begin
                  valid_ff[act_idx_ff] <= 1'b0;
                  avail_ff[act_idx_ff] <= 1'b0;
                  reg_ff[act_idx_ff]   <= 1'b0;
                  held_ff[act_idx_ff]  <= 1'b0;
               end
               MODE_CLOSE: begin
                  avail_ff[act_idx_ff] <= 1'b1;
                  held_ff[act_idx_ff]  <= 1'b0;
               end
               default: ;
            endcase
         end
      end
   end

   // Payload registers: no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      ptr_ff      <= ptr_in;
      cur_ff      <= ptr_ff;
      best_ff     <= best_in;
      best_key_ff <= best_key_in;
      found_ff    <= found_in;
      act_idx_ff  <= act_idx_in;
      rsp_ff      <= rsp_in;
   end
endmodule
